// ===== hdl/atcs_pkg.sv =====
// ----------------------------------------------------------------------------
// AT command sequencer package
// Shared types, codes and sizes of the command queue and response sequencer.
// ----------------------------------------------------------------------------
package atcs_pkg;

	localparam int QUEUE_DEPTH       = 1024;
	localparam int MAX_COMMAND_BYTES = 64;
	localparam int IDX_W             = $clog2(QUEUE_DEPTH);
	localparam int CNT_W             = 11;
	localparam int LEN_W             = 7;
	localparam int LIMIT_W           = 16;
	localparam int CMDQ_DEPTH        = 2;
	localparam int CMDQ_IDX_W        = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W        = $clog2(CMDQ_DEPTH + 1);

	localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [7:0]         NEWLINE       = 8'h0A;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_OK   = 2'd2;
	localparam logic [1:0] ACT_ERR  = 2'd3;

	localparam logic [1:0] SEQ_READY = 2'd0;
	localparam logic [1:0] SEQ_WAIT  = 2'd1;
	localparam logic [1:0] SEQ_DONE  = 2'd2;

	localparam logic [1:0] OC_SUCCESS = 2'd0;
	localparam logic [1:0] OC_TIMEOUT = 2'd1;
	localparam logic [1:0] OC_FAILED  = 2'd2;
	localparam logic [1:0] OC_UNDEF   = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] command_length;
		logic             first_byte;
	} item_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       tx_byte;
		logic             last_item;
		logic [1:0]       engine_state;
		logic [1:0]       outcome;
		logic             push_accepted;
		logic [CNT_W-1:0] queue_count;
	} result_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] length;
		logic             first;
		logic             length_ok;
	} cmd_t;

endpackage

// ===== hdl/at_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// AT command sequencer
// Queues newline-terminated command bytes, sends one command per tick and
// tracks the OK, ERROR or timeout outcome of each command.
// ----------------------------------------------------------------------------
// Each status result is registered; input transfers wait in the front-end queue
// while the back end dispatches. A dispatching tick scans the queue memory byte by
// byte through SCAN_A and SCAN_B, then sends one byte result per pass through
// EMIT_A and EMIT_B. Throughput: one status item every cycle while not dispatching.
// Reset clears all control state and sets the timeout limit to 5000.
// The receiver cannot stall; each result is shown for one cycle only.
module at_command_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  atcs_pkg::item_t               item,
	input  logic                          cfg_we,
	input  logic [atcs_pkg::LIMIT_W-1:0]  cfg_wdata,
	output atcs_pkg::result_t             result,
	output logic                          result_valid
);

	logic            cmd_valid;
	atcs_pkg::cmd_t  cmd;
	logic            cmd_pop;

	atcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	atcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== hdl/atcs_front.sv =====
// ----------------------------------------------------------------------------
// AT command sequencer front end
// Takes input transfers, checks the push length and holds them in a short
// queue until the back end is free to carry them out.
// ----------------------------------------------------------------------------
module atcs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  atcs_pkg::item_t        item,
	output logic                   cmd_valid,
	output atcs_pkg::cmd_t         cmd,
	input  logic                   cmd_pop
);

	atcs_pkg::cmd_t                      entry_q [atcs_pkg::CMDQ_DEPTH];
	logic [atcs_pkg::CMDQ_IDX_W-1:0]     wp_q;
	logic [atcs_pkg::CMDQ_IDX_W-1:0]     rp_q;
	logic [atcs_pkg::CMDQ_CNT_W-1:0]     cnt_q;
	atcs_pkg::cmd_t                      cls;
	logic                                push;
	logic                                pop;

	assign busy      = (cnt_q == atcs_pkg::CMDQ_CNT_W'(atcs_pkg::CMDQ_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rp_q];

	always_comb begin
		cls.action    = item.action;
		cls.data_byte = item.data_byte;
		cls.length    = item.command_length;
		cls.first     = item.first_byte;
		cls.length_ok = (item.command_length != '0) &&
			(item.command_length <= atcs_pkg::LEN_W'(atcs_pkg::MAX_COMMAND_BYTES));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == atcs_pkg::CMDQ_IDX_W'(atcs_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == atcs_pkg::CMDQ_IDX_W'(atcs_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/atcs_back.sv =====
// ----------------------------------------------------------------------------
// AT command sequencer back end
// Owns the byte ring queue and the response sequencer, carries out queued
// commands and drives the result strobe.
// ----------------------------------------------------------------------------
module atcs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  atcs_pkg::cmd_t                    cmd,
	output logic                              cmd_pop,
	input  logic                              cfg_we,
	input  logic [atcs_pkg::LIMIT_W-1:0]      cfg_wdata,
	output atcs_pkg::result_t                 result,
	output logic                              result_valid
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN_A = 3'd1;
	localparam logic [2:0] ST_SCAN_B = 3'd2;
	localparam logic [2:0] ST_EMIT_A = 3'd3;
	localparam logic [2:0] ST_EMIT_B = 3'd4;

	logic [7:0]                      mem [atcs_pkg::QUEUE_DEPTH];
	logic [7:0]                      rdata_q;
	logic [2:0]                      state_q;
	logic [atcs_pkg::IDX_W-1:0]      wr_idx_q;
	logic [atcs_pkg::IDX_W-1:0]      rd_idx_q;
	logic [atcs_pkg::IDX_W-1:0]      ptr_q;
	logic [atcs_pkg::CNT_W-1:0]      count_q;
	logic [atcs_pkg::LEN_W-1:0]      rem_q;
	logic [1:0]                      seq_q;
	logic [atcs_pkg::LIMIT_W-1:0]    wait_q;
	logic [1:0]                      outc_q;
	logic [atcs_pkg::LIMIT_W-1:0]    limit_q;
	logic [atcs_pkg::LEN_W-1:0]      n_q;
	logic [atcs_pkg::LEN_W-1:0]      k_q;
	atcs_pkg::result_t               res_q;
	logic                            res_v_q;

	logic [atcs_pkg::CNT_W-1:0]      c_count;
	logic [atcs_pkg::IDX_W-1:0]      c_wr;
	logic [atcs_pkg::IDX_W-1:0]      c_rd;
	logic [atcs_pkg::LEN_W-1:0]      c_rem;
	logic [1:0]                      c_seq;
	logic [atcs_pkg::LIMIT_W-1:0]    c_wait;
	logic [1:0]                      c_outc;
	logic                            c_acc;
	logic                            c_we;
	logic                            c_scan;
	logic [atcs_pkg::CNT_W-1:0]      free_cnt;

	logic [atcs_pkg::IDX_W-1:0]      ptr_nxt;
	logic [atcs_pkg::LEN_W-1:0]      n_inc;
	logic                            scan_stop;
	logic                            emit_last;

	assign cmd_pop      = (state_q == ST_IDLE) && cmd_valid;
	assign result       = res_q;
	assign result_valid = res_v_q;

	function automatic logic [atcs_pkg::IDX_W-1:0] idx_next(
		input logic [atcs_pkg::IDX_W-1:0] i
	);
		idx_next = (i == atcs_pkg::IDX_W'(atcs_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign ptr_nxt   = idx_next(ptr_q);
	assign n_inc     = n_q + 1'b1;
	assign scan_stop = (rdata_q == atcs_pkg::NEWLINE) ||
		(n_inc == atcs_pkg::LEN_W'(atcs_pkg::MAX_COMMAND_BYTES)) ||
		(atcs_pkg::CNT_W'(n_inc) == count_q);
	assign emit_last = ((k_q + 1'b1) == n_q);
	assign free_cnt  = atcs_pkg::CNT_W'(atcs_pkg::QUEUE_DEPTH) - count_q;

	always_comb begin
		c_count = count_q;
		c_wr    = wr_idx_q;
		c_rd    = rd_idx_q;
		c_rem   = rem_q;
		c_seq   = seq_q;
		c_wait  = wait_q;
		c_outc  = outc_q;
		c_acc   = 1'b0;
		c_we    = 1'b0;
		c_scan  = 1'b0;
		case (cmd.action)
			atcs_pkg::ACT_PUSH: begin
				if (cmd.first) begin
					c_rem = (cmd.length_ok &&
						(free_cnt >= atcs_pkg::CNT_W'(cmd.length))) ? cmd.length : '0;
				end
				if ((c_rem != '0) &&
					(count_q < atcs_pkg::CNT_W'(atcs_pkg::QUEUE_DEPTH))) begin
					c_we    = cmd_pop;
					c_wr    = idx_next(wr_idx_q);
					c_count = count_q + 1'b1;
					c_rem   = c_rem - 1'b1;
					c_acc   = 1'b1;
				end
			end
			atcs_pkg::ACT_TICK: begin
				case (seq_q)
					atcs_pkg::SEQ_READY: begin
						if (count_q == '0) begin
							c_wr = '0;
							c_rd = '0;
						end else begin
							c_scan = 1'b1;
						end
					end
					atcs_pkg::SEQ_WAIT: begin
						if (wait_q != '1) begin
							c_wait = wait_q + 1'b1;
						end
						if (c_wait >= limit_q) begin
							c_outc = atcs_pkg::OC_TIMEOUT;
							c_seq  = atcs_pkg::SEQ_DONE;
						end
					end
					default: begin
						c_seq = atcs_pkg::SEQ_READY;
					end
				endcase
			end
			default: begin
				if (seq_q == atcs_pkg::SEQ_WAIT) begin
					c_seq  = atcs_pkg::SEQ_DONE;
					c_outc = (cmd.action == atcs_pkg::ACT_OK) ?
						atcs_pkg::OC_SUCCESS : atcs_pkg::OC_FAILED;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			mem[wr_idx_q] <= cmd.data_byte;
		end
		rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_B) begin
			res_q.kind          <= 1'b1;
			res_q.tx_byte       <= rdata_q;
			res_q.last_item     <= emit_last;
			res_q.engine_state  <= seq_q;
			res_q.outcome       <= outc_q;
			res_q.push_accepted <= 1'b0;
			res_q.queue_count   <= count_q;
		end else begin
			res_q.kind          <= 1'b0;
			res_q.tx_byte       <= '0;
			res_q.last_item     <= 1'b1;
			res_q.engine_state  <= c_seq;
			res_q.outcome       <= c_outc;
			res_q.push_accepted <= c_acc;
			res_q.queue_count   <= c_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			ptr_q    <= '0;
			count_q  <= '0;
			rem_q    <= '0;
			seq_q    <= atcs_pkg::SEQ_READY;
			wait_q   <= '0;
			outc_q   <= atcs_pkg::OC_UNDEF;
			limit_q  <= atcs_pkg::TIMEOUT_RESET;
			n_q      <= '0;
			k_q      <= '0;
			res_v_q  <= 1'b0;
		end else begin
			res_v_q <= ((state_q == ST_IDLE) && cmd_valid && !c_scan) ||
				(state_q == ST_EMIT_B);
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (c_scan) begin
							state_q <= ST_SCAN_A;
							ptr_q   <= rd_idx_q;
							n_q     <= '0;
						end else begin
							wr_idx_q <= c_wr;
							rd_idx_q <= c_rd;
							count_q  <= c_count;
							rem_q    <= c_rem;
							seq_q    <= c_seq;
							wait_q   <= c_wait;
							outc_q   <= c_outc;
						end
					end
				end
				ST_SCAN_A: begin
					state_q <= ST_SCAN_B;
				end
				ST_SCAN_B: begin
					n_q <= n_inc;
					if (scan_stop) begin
						count_q  <= count_q - atcs_pkg::CNT_W'(n_inc);
						rd_idx_q <= ptr_nxt;
						ptr_q    <= rd_idx_q;
						seq_q    <= atcs_pkg::SEQ_WAIT;
						wait_q   <= '0;
						outc_q   <= atcs_pkg::OC_UNDEF;
						k_q      <= '0;
						state_q  <= ST_EMIT_A;
					end else begin
						ptr_q   <= ptr_nxt;
						state_q <= ST_SCAN_A;
					end
				end
				ST_EMIT_A: begin
					state_q <= ST_EMIT_B;
				end
				ST_EMIT_B: begin
					ptr_q   <= ptr_nxt;
					k_q     <= k_q + 1'b1;
					state_q <= emit_last ? ST_IDLE : ST_EMIT_A;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_at_command_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AT command sequencer testbench
// Walks a short list of directed pushes, ticks and responses, then random
// command traffic under several timeout limits. Every result transfer is checked
// field by field against a typed row's want or a cycle-free sequencer model.
// ----------------------------------------------------------------------------
module tb_at_command_sequencer;
	import atcs_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE       = 4 * MAX_COMMAND_BYTES + 16;
	localparam int PHASE_ITEMS  = 44;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		bit                 is_cfg;
		logic [LIMIT_W-1:0] limit;
		item_t              it;
		bit                 typed;
		result_t            want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	item_t              item = '0;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	result_t            result;
	logic               result_valid;

	logic               typed_row = 1'b0;
	result_t            typed_want = '0;

	logic [7:0]         q_mem [QUEUE_DEPTH];
	int                 q_wr = 0;
	int                 q_rd = 0;
	int                 q_count = 0;
	int                 left_to_push = 0;
	bit                 push_open = 1'b0;
	logic [1:0]         seq_state = SEQ_READY;
	logic [1:0]         cur_outcome = OC_UNDEF;
	int                 wait_ticks = 0;
	logic [LIMIT_W-1:0] timeout_ticks = TIMEOUT_RESET;

	result_t            step_results [$];
	result_t            pending_results [$];
	row_t               directed_rows [$];

	int                 error_count = 0;
	int                 items_accepted = 0;
	int                 results_checked = 0;
	int                 commands_sent = 0;
	int                 successes = 0;
	int                 failures = 0;
	int                 timeouts = 0;
	int                 refused_pushes = 0;
	int                 limits_written = 0;
	int                 idle_cycles = 0;
	int                 burst_left = 0;
	bit                 gaps_on = 1'b1;

	at_command_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_valid (result_valid)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic result_t make_result(logic is_byte, logic [7:0] b, logic last,
			logic stored);
		result_t r;
		r.kind          = is_byte;
		r.tx_byte       = b;
		r.last_item     = last;
		r.engine_state  = seq_state;
		r.outcome       = cur_outcome;
		r.push_accepted = stored;
		r.queue_count   = q_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic predict_sequencer(input item_t it);
		logic [7:0] sent [$];
		logic [7:0] b;
		int         len;
		bit         stored;
		bit         stop;
		step_results.delete();
		len    = it.command_length;
		stored = 1'b0;
		case (it.action)
			ACT_PUSH: begin
				if (it.first_byte) begin
					if (len >= 1 && len <= MAX_COMMAND_BYTES && QUEUE_DEPTH - q_count >= len) begin
						push_open    = 1'b1;
						left_to_push = len;
					end else begin
						push_open    = 1'b0;
						left_to_push = 0;
						refused_pushes++;
					end
				end
				if (push_open && left_to_push > 0 && q_count < QUEUE_DEPTH) begin
					q_mem[q_wr] = it.data_byte;
					q_wr = (q_wr + 1) % QUEUE_DEPTH;
					q_count++;
					left_to_push--;
					stored = 1'b1;
				end
				if (left_to_push == 0)
					push_open = 1'b0;
			end
			ACT_TICK: begin
				if (seq_state == SEQ_READY) begin
					if (q_count == 0) begin
						q_wr = 0;
						q_rd = 0;
					end else begin
						stop = 1'b0;
						while (!stop && sent.size() < MAX_COMMAND_BYTES && q_count > 0) begin
							b = q_mem[q_rd];
							q_rd = (q_rd + 1) % QUEUE_DEPTH;
							q_count--;
							sent.push_back(b);
							stop = (b == NEWLINE);
						end
						wait_ticks  = 0;
						cur_outcome = OC_UNDEF;
						seq_state   = SEQ_WAIT;
						commands_sent++;
					end
				end else if (seq_state == SEQ_WAIT) begin
					if (wait_ticks < 65535)
						wait_ticks++;
					if (wait_ticks >= timeout_ticks) begin
						cur_outcome = OC_TIMEOUT;
						seq_state   = SEQ_DONE;
						timeouts++;
					end
				end else begin
					seq_state = SEQ_READY;
				end
			end
			default: begin
				if (seq_state == SEQ_WAIT) begin
					seq_state = SEQ_DONE;
					if (it.action == ACT_OK) begin
						cur_outcome = OC_SUCCESS;
						successes++;
					end else begin
						cur_outcome = OC_FAILED;
						failures++;
					end
				end
			end
		endcase
		if (sent.size() > 0) begin
			foreach (sent[k])
				step_results.push_back(make_result(1'b1, sent[k], k == sent.size() - 1, 1'b0));
		end else begin
			step_results.push_back(make_result(1'b0, 8'h00, 1'b1, stored));
		end
	endtask

	function automatic string describe(result_t r);
		return $sformatf("kind %0d byte %02h last %0d state %0d outcome %0d accepted %0d count %0d",
			r.kind, r.tx_byte, r.last_item, r.engine_state, r.outcome, r.push_accepted,
			r.queue_count);
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("Unexpected result transfer at %0t: %s", $time, describe(got));
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
				got.last_item !== want.last_item || got.engine_state !== want.engine_state ||
				got.outcome !== want.outcome || got.push_accepted !== want.push_accepted ||
				got.queue_count !== want.queue_count) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("Mismatch at %0t", $time);
				$display("  expected %s", describe(want));
				$display("  actual   %s", describe(got));
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				check_result(result);
			if (start && !busy) begin
				items_accepted++;
				predict_sequencer(item);
				if (typed_row)
					pending_results.push_back(typed_want);
				else
					foreach (step_results[k])
						pending_results.push_back(step_results[k]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("No transfer for %0d cycles, run abandoned", STALL_LIMIT);
			$display("tb_at_command_sequencer: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic item_t make_item(logic [1:0] act, logic [7:0] d, logic [LEN_W-1:0] len,
			logic first);
		item_t it;
		it.action         = act;
		it.data_byte      = d;
		it.command_length = len;
		it.first_byte     = first;
		return it;
	endfunction

	function automatic result_t idle_status(logic stored, int count);
		result_t r;
		r.kind          = 1'b0;
		r.tx_byte       = 8'h00;
		r.last_item     = 1'b1;
		r.engine_state  = SEQ_READY;
		r.outcome       = OC_UNDEF;
		r.push_accepted = stored;
		r.queue_count   = count[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		return (b >= NEWLINE) ? b + 8'd1 : b;
	endfunction

	function automatic void add_item_row(item_t it, bit typed, result_t want);
		row_t r;
		r.is_cfg = 1'b0;
		r.limit  = '0;
		r.it     = it;
		r.typed  = typed;
		r.want   = want;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_limit_row(logic [LIMIT_W-1:0] value);
		row_t r;
		r.is_cfg = 1'b1;
		r.limit  = value;
		r.it     = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void build_directed_rows();
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_OK, 8'hFF, 7'd127, 1'b1), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_ERR, 8'h00, 7'd64, 1'b0), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_PUSH, 8'hFF, 7'd0, 1'b1), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_PUSH, 8'h00, 7'd127, 1'b1), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_PUSH, 8'h41, 7'd3, 1'b0), 1'b1, idle_status(1'b0, 0));
		add_item_row(make_item(ACT_PUSH, 8'h41, 7'd3, 1'b1), 1'b1, idle_status(1'b1, 1));
		add_item_row(make_item(ACT_PUSH, 8'h54, 7'd0, 1'b0), 1'b1, idle_status(1'b1, 2));
		add_item_row(make_item(ACT_PUSH, NEWLINE, 7'd0, 1'b0), 1'b1, idle_status(1'b1, 3));
		add_item_row(make_item(ACT_PUSH, 8'h55, 7'd0, 1'b0), 1'b1, idle_status(1'b0, 3));
		add_item_row(make_item(ACT_PUSH, 8'hFF, 7'd64, 1'b1), 1'b1, idle_status(1'b1, 4));
		add_item_row(make_item(ACT_PUSH, NEWLINE, 7'd1, 1'b1), 1'b1, idle_status(1'b1, 5));
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_OK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_ERR, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_PUSH, 8'h00, 7'd2, 1'b1), 1'b0, '0);
		add_item_row(make_item(ACT_PUSH, 8'h7E, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_limit_row(16'd0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_limit_row(16'd1);
		add_item_row(make_item(ACT_PUSH, NEWLINE, 7'd1, 1'b1), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
		add_item_row(make_item(ACT_TICK, 8'h00, 7'd0, 1'b0), 1'b0, '0);
	endfunction

	task automatic send_item(input item_t it, input bit typed, input result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start      <= 1'b1;
		item       <= it;
		typed_row  <= typed;
		typed_want <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send(input item_t it);
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_control(input logic [1:0] act);
		send(make_item(act, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)),
			1'($urandom_range(0, 1))));
	endtask

	// The length field rides on the first byte only; later bytes carry noise there.
	task automatic push_command(input int len, input int count, input bit terminated,
			input bit plain);
		logic [7:0] d;
		for (int k = 0; k < count; k++) begin
			if (terminated && k == count - 1)
				d = NEWLINE;
			else if (plain)
				d = plain_byte();
			else
				d = 8'($urandom_range(0, 255));
			send(make_item(ACT_PUSH, d,
				(k == 0) ? LEN_W'(len) : LEN_W'($urandom_range(0, 127)), k == 0));
		end
	endtask

	task automatic broken_command();
		int len;
		case ($urandom_range(0, 2))
			0: begin
				len = $urandom_range(2, 12);
				push_command(len, $urandom_range(1, len - 1), 1'b0, 1'b0);
			end
			1: begin
				len = $urandom_range(1, 8);
				push_command(len, len + $urandom_range(1, 3), 1'b1, 1'b0);
			end
			default: begin
				len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_COMMAND_BYTES + 1, 127);
				push_command(len, $urandom_range(1, 4), 1'b1, 1'b0);
			end
		endcase
	endtask

	task automatic random_traffic(input int quota);
		item_t noise;
		int    goal;
		int    len;
		int    pick;
		goal = items_accepted + quota;
		while (items_accepted < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, MAX_COMMAND_BYTES)
					: $urandom_range(1, 12);
				push_command(len, len, $urandom_range(0, 9) != 0, 1'b0);
			end else if (pick < 65) begin
				repeat ($urandom_range(1, 3))
					send_control(ACT_TICK);
			end else if (pick < 77) begin
				send_control($urandom_range(0, 1) ? ACT_OK : ACT_ERR);
			end else if (pick < 89) begin
				broken_command();
			end else begin
				noise = item_t'($bits(item_t)'($urandom));
				send(noise);
			end
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		timeout_ticks  = value;
		limits_written++;
	endtask

	initial begin
		build_directed_rows();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_limit(directed_rows[i].limit);
			else
				send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
		end

		write_limit(16'hFFFF);
		random_traffic(PHASE_ITEMS);
		write_limit(16'd3);
		random_traffic(PHASE_ITEMS);
		gaps_on = 1'b0;
		write_limit(LIMIT_W'($urandom_range(4, 40)));
		random_traffic(PHASE_ITEMS);
		gaps_on = 1'b1;
		write_limit(16'd1);
		random_traffic(PHASE_ITEMS);
		drain_results();

		$display("Run covered %0d input transfers and %0d result transfers over %0d limit settings.",
			items_accepted, results_checked, limits_written);
		$display("Commands sent %0d: %0d ok, %0d error, %0d timed out; %0d pushes refused.",
			commands_sent, successes, failures, timeouts, refused_pushes);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_at_command_sequencer: done, clean");
		else
			$display("tb_at_command_sequencer: done, errors");
		$finish;
	end

endmodule

// ===== at_command_sequencer.f =====
hdl/atcs_pkg.sv
hdl/atcs_front.sv
hdl/atcs_back.sv
hdl/at_command_sequencer.sv
tb/tb_at_command_sequencer.sv
